@@ hdl/crt_three_congruence_solver_core_macros.svh @@
// assertion macros for the three congruence solver
`ifndef CRT_THREE_CONGRUENCE_SOLVER_CORE_MACROS_SVH
`define CRT_THREE_CONGRUENCE_SOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same cycle implication
`define CRT3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crt3 check failed");
// next cycle implication
`define CRT3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crt3 check failed");
`else
`define CRT3_ASSERT_NOW(label, ante, cons)
`define CRT3_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/crt3_pkg.sv @@
// shared types and constants for the three congruence solver
`timescale 1ns / 1ps
`default_nettype none
package crt3_pkg;
  localparam int FIELD_W = 16;
  localparam int OUT_W   = 48;

  // result status codes
  typedef enum logic [1:0] {
    ST_SOLVED     = 2'd0,
    ST_NOT_COPRIME = 2'd1,
    ST_ZERO_MOD   = 2'd2
  } status_t;

  // lane status toward the merge stage
  typedef struct packed {
    logic done;
    logic coprime;
  } lane_stat_t;
endpackage
`default_nettype wire

@@ hdl/crt3_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module crt3_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot,
  output logic [DEN_W-1:0]      rem
);
  localparam int CW = $clog2(NUM_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;

  // one shift and trial subtract per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, num_r[NUM_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(NUM_W);
      num_nxt = num;
      quo_nxt = '0;
      rem_nxt = '0;
      den_nxt = den;
    end else if (run_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

@@ hdl/crt3_smul.sv @@
// shift and add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module crt3_smul #(
  parameter int A_W = 32,
  parameter int B_W = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      prod
);
  localparam int PW = A_W + B_W;
  localparam int CW = $clog2(B_W + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] a_r, a_nxt;
  logic [B_W-1:0] b_r, b_nxt;
  logic [PW-1:0] acc_r, acc_nxt;

  // add shifted multiplicand when the low multiplier bit is set
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(B_W);
      a_nxt   = {{B_W{1'b0}}, a};
      b_nxt   = b;
      acc_nxt = '0;
    end else if (run_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt   = {a_r[PW-2:0], 1'b0};
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

@@ hdl/crt3_lane.sv @@
// one congruence lane: cofactor, coprimality, inverse and weighted term
`timescale 1ns / 1ps
`default_nettype none
module crt3_lane #(
  parameter int MB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [MB-1:0] res_self,
  input  wire logic [MB-1:0] mod_self,
  input  wire logic [MB-1:0] mod_o1,
  input  wire logic [MB-1:0] mod_o2,
  output crt3_pkg::lane_stat_t stat,
  output logic [3*MB-1:0]    term
);
  typedef enum logic [8:0] {
    L_IDLE  = 9'b000000001,
    L_COF   = 9'b000000010,
    L_RED   = 9'b000000100,
    L_EUC   = 9'b000001000,
    L_EDIV  = 9'b000010000,
    L_RS    = 9'b000100000,
    L_RSDIV = 9'b001000000,
    L_TERM  = 9'b010000000,
    L_DONE  = 9'b100000000
  } lstate_t;

  lstate_t             state_r, state_nxt;
  logic [MB-1:0]       m_r, r_in_r;
  logic [2*MB-1:0]     cof_r;
  logic [MB-1:0]       oldr_r, rr_r, inv_r;
  logic signed [MB+1:0] olds_r, s_r;
  logic                cop_r, cop_nxt;
  logic [3*MB-1:0]     term_r;

  logic                div_start, div_done;
  logic [2*MB-1:0]     div_num, div_quot;
  logic [MB-1:0]       div_den, div_rem;
  logic                mul_start, mul_done;
  logic [2*MB-1:0]     mul_a;
  logic [MB-1:0]       mul_b;
  logic [3*MB-1:0]     mul_prod;

  logic signed [2*MB+2:0] qs;
  logic signed [2*MB+2:0] s_diff;
  logic signed [MB+1:0]   s_fix;

  crt3_div #(.NUM_W(2*MB), .DEN_W(MB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  crt3_smul #(.A_W(2*MB), .B_W(MB)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  // euclid update of the bezout coefficient
  assign qs     = (2*MB+3)'($signed({1'b0, div_quot[MB-1:0]})) * (2*MB+3)'(s_r);
  assign s_diff = {{(MB+1){olds_r[MB+1]}}, olds_r} - qs;
  assign s_fix  = olds_r + $signed({2'b00, m_r});

  // sequencer and shared unit steering
  always_comb begin
    state_nxt = state_r;
    cop_nxt   = cop_r;
    div_start = 1'b0;
    div_num   = cof_r;
    div_den   = m_r;
    mul_start = 1'b0;
    mul_a     = {{MB{1'b0}}, mod_o1};
    mul_b     = mod_o2;
    unique case (state_r)
      L_IDLE, L_DONE: begin
        if (start) begin
          mul_start = 1'b1;
          state_nxt = L_COF;
        end
      end
      L_COF: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod[2*MB-1:0];
          state_nxt = L_RED;
        end
      end
      L_RED: begin
        if (div_done) state_nxt = L_EUC;
      end
      L_EUC: begin
        if (rr_r == '0) begin
          cop_nxt   = (oldr_r == MB'(1));
          state_nxt = (oldr_r == MB'(1)) ? L_RS : L_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = {{MB{1'b0}}, oldr_r};
          div_den   = rr_r;
          state_nxt = L_EDIV;
        end
      end
      L_EDIV: begin
        if (div_done) state_nxt = L_EUC;
      end
      L_RS: begin
        div_start = 1'b1;
        div_num   = {{MB{1'b0}}, r_in_r} * {{MB{1'b0}}, inv_r};
        state_nxt = L_RSDIV;
      end
      L_RSDIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = cof_r;
          mul_b     = div_rem;
          state_nxt = L_TERM;
        end
      end
      L_TERM: begin
        if (mul_done) state_nxt = L_DONE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cop_r   <= cop_nxt;
    end
    if ((state_r == L_IDLE || state_r == L_DONE) && start) begin
      m_r    <= mod_self;
      r_in_r <= res_self;
    end
    if (state_r == L_COF && mul_done) cof_r <= mul_prod[2*MB-1:0];
    if (state_r == L_RED && div_done) begin
      oldr_r <= div_rem;
      rr_r   <= m_r;
      olds_r <= (MB+2)'(1);
      s_r    <= '0;
    end
    if (state_r == L_EDIV && div_done) begin
      oldr_r <= rr_r;
      rr_r   <= div_rem;
      olds_r <= s_r;
      s_r    <= s_diff[MB+1:0];
    end
    if (state_r == L_EUC && rr_r == '0) begin
      inv_r <= olds_r[MB+1] ? s_fix[MB-1:0] : olds_r[MB-1:0];
    end
    if (state_r == L_TERM && mul_done) term_r <= mul_prod;
  end

  assign stat.done    = (state_r == L_DONE);
  assign stat.coprime = cop_r;
  assign term         = term_r;
endmodule
`default_nettype wire

@@ hdl/crt_three_congruence_solver_core.sv @@
// Three congruence CRT solver, one item at a time through three parallel lanes.
// A zero modulus skips the lanes and goes straight from accept to the result
// stage. A new item is taken only once the result of the last one has been
// registered, as in_ready is high only in idle.
// Synchronous active-low reset clears control; the block is ready right after.
`timescale 1ns / 1ps
`default_nettype none
`include "crt_three_congruence_solver_core_macros.svh"
module crt_three_congruence_solver_core #(
  parameter int MOD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_residue_a,
  input  wire logic [15:0] in_modulus_a,
  input  wire logic [15:0] in_residue_b,
  input  wire logic [15:0] in_modulus_b,
  input  wire logic [15:0] in_residue_c,
  input  wire logic [15:0] in_modulus_c,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_solution,
  output logic [47:0]      out_combined_modulus,
  output logic [1:0]       out_status,
  output logic [1:0]       out_failing_index
);
  localparam int MB = MOD_BITS;
  localparam int PW = 3 * MB;
  localparam int FW = crt3_pkg::FIELD_W;
  localparam int OW = crt3_pkg::OUT_W;

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_P1   = 6'b000010,
    T_P2   = 6'b000100,
    T_WAIT = 6'b001000,
    T_SUM  = 6'b010000,
    T_FIN  = 6'b100000
  } tstate_t;

  tstate_t              state_r, state_nxt;
  logic [FW+MB-1:0]     fld_ext [6];
  logic [MB-1:0]        res_in [3];
  logic [MB-1:0]        mod_in [3];
  logic [MB-1:0]        m2_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        sum_r;
  logic [1:0]           idx_r;
  logic [PW:0]          sum_add;
  logic [PW:0]          sum_red;
  crt3_pkg::status_t    st_r;
  logic [1:0]           fi_r;
  logic                 accept, any_zero, lanes_done, any_bad;
  logic [1:0]           zero_idx, bad_idx;
  crt3_pkg::lane_stat_t lane_stat [3];
  logic [PW-1:0]        lane_term [3];
  logic                 mul_start, mul_done;
  logic [2*MB-1:0]      mul_a;
  logic [MB-1:0]        mul_b;
  logic [PW-1:0]        mul_prod;
  logic [PW+OW-1:0]     sol_ext, cm_ext;

  logic                 out_valid_r;
  logic [OW-1:0]        out_sol_r, out_cm_r;
  logic [1:0]           out_st_r, out_fi_r;

  // low MOD_BITS bits of each field, zero extended when wider
  assign fld_ext[0] = {{MB{1'b0}}, in_residue_a};
  assign fld_ext[1] = {{MB{1'b0}}, in_modulus_a};
  assign fld_ext[2] = {{MB{1'b0}}, in_residue_b};
  assign fld_ext[3] = {{MB{1'b0}}, in_modulus_b};
  assign fld_ext[4] = {{MB{1'b0}}, in_residue_c};
  assign fld_ext[5] = {{MB{1'b0}}, in_modulus_c};

  for (genvar g = 0; g < 3; g++) begin : g_field
    assign res_in[g] = fld_ext[2*g][MB-1:0];
    assign mod_in[g] = fld_ext[2*g+1][MB-1:0];
  end

  assign accept = in_valid && in_ready;

  // first zero modulus in order a, b, c
  always_comb begin
    any_zero = 1'b0;
    zero_idx = 2'd0;
    for (int i = 2; i >= 0; i--) begin
      if (mod_in[i] == '0) begin
        any_zero = 1'b1;
        zero_idx = 2'(i + 1);
      end
    end
  end

  // lanes, one per congruence
  for (genvar g = 0; g < 3; g++) begin : g_lane
    crt3_lane #(.MB(MB)) u_lane (
      .clk(clk), .rst_n(rst_n), .start(accept && !any_zero),
      .res_self(res_in[g]), .mod_self(mod_in[g]),
      .mod_o1(mod_in[(g+1)%3]), .mod_o2(mod_in[(g+2)%3]),
      .stat(lane_stat[g]), .term(lane_term[g])
    );
  end

  // merge view of lane status
  always_comb begin
    lanes_done = lane_stat[0].done && lane_stat[1].done && lane_stat[2].done;
    any_bad    = 1'b0;
    bad_idx    = 2'd0;
    for (int i = 2; i >= 0; i--) begin
      if (!lane_stat[i].coprime) begin
        any_bad = 1'b1;
        bad_idx = 2'(i + 1);
      end
    end
  end

  // product of the moduli in two serial passes
  crt3_smul #(.A_W(2*MB), .B_W(MB)) u_prod (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  // modular accumulation of the lane terms
  assign sum_add = {1'b0, sum_r} + {1'b0, lane_term[idx_r]};
  assign sum_red = (sum_add >= {1'b0, prod_r}) ? sum_add - {1'b0, prod_r} : sum_add;

  // merge sequencer
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = {{MB{1'b0}}, mod_in[0]};
    mul_b     = mod_in[1];
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          if (any_zero) begin
            state_nxt = T_FIN;
          end else begin
            mul_start = 1'b1;
            state_nxt = T_P1;
          end
        end
      end
      T_P1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod[2*MB-1:0];
          mul_b     = m2_r;
          state_nxt = T_P2;
        end
      end
      T_P2: begin
        if (mul_done) state_nxt = T_WAIT;
      end
      T_WAIT: begin
        if (lanes_done) state_nxt = any_bad ? T_FIN : T_SUM;
      end
      T_SUM: begin
        if (idx_r == 2'd2) state_nxt = T_FIN;
      end
      T_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == T_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // item capture
    if (state_r == T_IDLE && accept) begin
      m2_r   <= mod_in[2];
      prod_r <= '0;
      sum_r  <= '0;
      idx_r  <= 2'd0;
      st_r   <= any_zero ? crt3_pkg::ST_ZERO_MOD : crt3_pkg::ST_SOLVED;
      fi_r   <= any_zero ? zero_idx : 2'd0;
    end
    if (state_r == T_P2 && mul_done) prod_r <= mul_prod;
    if (state_r == T_WAIT && lanes_done && any_bad) begin
      st_r <= crt3_pkg::ST_NOT_COPRIME;
      fi_r <= bad_idx;
    end
    if (state_r == T_SUM) begin
      sum_r <= sum_red[PW-1:0];
      idx_r <= idx_r + 2'd1;
    end
    // result word register
    if (state_r == T_FIN && (!out_valid_r || out_ready)) begin
      out_sol_r <= (st_r == crt3_pkg::ST_SOLVED) ? sol_ext[OW-1:0] : '0;
      out_cm_r  <= cm_ext[OW-1:0];
      out_st_r  <= st_r;
      out_fi_r  <= fi_r;
    end
  end

  assign sol_ext = {{OW{1'b0}}, sum_r};
  assign cm_ext  = {{OW{1'b0}}, prod_r};

  assign in_ready             = (state_r == T_IDLE);
  assign out_valid            = out_valid_r;
  assign out_solution         = out_sol_r;
  assign out_combined_modulus = out_cm_r;
  assign out_status           = out_st_r;
  assign out_failing_index    = out_fi_r;

  `CRT3_ASSERT_NOW(a_solved_no_index,
    out_valid && out_status == crt3_pkg::ST_SOLVED, out_failing_index == 2'd0)
  `CRT3_ASSERT_NOW(a_error_zero_solution,
    out_valid && out_status != crt3_pkg::ST_SOLVED, out_solution == '0)
  `CRT3_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire
